@@ rtl/oav_pkg.sv @@
// Package with the types, constants and register codes of the oscillator voice.
`timescale 1ns / 1ps
`default_nettype none
package oav_pkg;

  localparam int unsigned SampleRateHz = 44100;
  localparam int unsigned MaxSeconds   = 5;

  localparam int unsigned IdxW  = 18;
  localparam int unsigned NumW  = 35;
  localparam int unsigned EnvW  = 17;
  localparam int unsigned BndW  = 21;

  localparam logic [IdxW-1:0] HoldLen = IdxW'(SampleRateHz / 2);
  localparam logic [BndW-1:0] MaxLen  = BndW'(MaxSeconds * SampleRateHz);
  localparam logic [EnvW-1:0] EnvOne  = 17'd65536;

  localparam logic [15:0] SquareAmp = 16'd19661;
  localparam logic [13:0] OutGain   = 14'd16000;
  localparam logic [31:0] LcgMul    = 32'd1103515245;
  localparam logic [31:0] LcgAdd    = 32'd12345;
  localparam logic [31:0] SeedInit  = 32'd12345;
  localparam logic [14:0] NoiseDiv  = 15'd32767;

  localparam logic [2:0]  RstWave    = 3'd0;
  localparam logic [31:0] RstStep    = 32'd42852282;
  localparam logic [17:0] RstAttack  = 18'd2205;
  localparam logic [17:0] RstDecay   = 18'd8820;
  localparam logic [16:0] RstSustain = 17'd39322;
  localparam logic [17:0] RstRelease = 18'd17640;

  localparam logic [2:0] WaveSine   = 3'd0;
  localparam logic [2:0] WaveSquare = 3'd1;
  localparam logic [2:0] WaveSaw    = 3'd2;
  localparam logic [2:0] WaveTri    = 3'd3;
  localparam logic [2:0] WaveNoise  = 3'd4;

  localparam logic [2:0] RegWave    = 3'd0;
  localparam logic [2:0] RegStep    = 3'd1;
  localparam logic [2:0] RegAttack  = 3'd2;
  localparam logic [2:0] RegDecay   = 3'd3;
  localparam logic [2:0] RegSustain = 3'd4;
  localparam logic [2:0] RegRelease = 3'd5;

  typedef struct packed {
    logic [2:0]  wave_sel;
    logic [31:0] phase_step;
    logic [17:0] attack_len;
    logic [17:0] decay_len;
    logic [16:0] sustain_lvl;
    logic [17:0] release_len;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [17:0]     den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEG, ST_WAVE, ST_DIV, ST_ENV, ST_GAIN, ST_DONE
  } eng_state_e;

  typedef enum logic [1:0] {
    SEG_ATTACK, SEG_DECAY, SEG_HOLD, SEG_RELEASE
  } seg_e;

endpackage
`default_nettype wire

@@ rtl/oav_front.sv @@
// Input side: accepts tick words and queues them for the sample engine.
`timescale 1ns / 1ps
`default_nettype none
module oav_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic note_start_i,
  output logic      q_valid_o,
  output logic      q_start_o,
  input  wire logic q_pop_i
);
  import oav_pkg::*;

  logic [1:0] mem_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_start_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= note_start_i;
  end

endmodule
`default_nettype wire

@@ rtl/oav_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module oav_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  oav_pkg::div_req_t      req_i,
  output oav_pkg::div_rsp_t      rsp_o
);
  import oav_pkg::*;

  logic [NumW-1:0] sh_q;
  logic [17:0]     rem_q;
  logic [5:0]      cnt_q;
  logic            done_q;
  logic [18:0]     trial;
  logic [19:0]     diff;

  assign trial = {rem_q, sh_q[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, req_i.den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= 6'(NumW);
      end else if (cnt_q != 6'd0) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.num;
      rem_q <= 18'd0;
    end else if (cnt_q != 6'd0) begin
      if (!diff[19]) begin
        rem_q <= diff[17:0];
        sh_q  <= {sh_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial[17:0];
        sh_q  <= {sh_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule
`default_nettype wire

@@ rtl/oav_engine.sv @@
// Sample engine: oscillator, envelope sequencer and output word register.
`timescale 1ns / 1ps
`default_nettype none
module oav_engine (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  oav_pkg::cfg_t     cfg_i,
  input  wire logic         q_valid_i,
  input  wire logic         q_start_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic signed [14:0] sample_out_o,
  output logic              last_sample_o,
  output logic              note_active_o
);
  import oav_pkg::*;

  eng_state_e state_q, state_d;

  logic [31:0]     phase_q;
  logic [IdxW-1:0] idx_q;
  logic [31:0]     seed_q;
  logic            run_q;
  logic [IdxW-1:0] len_q;
  seg_e            seg_q;
  logic [NumW-1:0] num_q;
  logic [17:0]     den_q;
  logic            wneg_q;
  logic [15:0]     wmag_q;
  logic [EnvW-1:0] env_q;
  logic [32:0]     prod_q;
  logic signed [14:0] res_q;
  logic            res_last_q, res_act_q;
  logic            ov_q;
  logic signed [14:0] osamp_q;
  logic            olast_q, oact_q;

  logic [BndW-1:0] sum_len, b1, b2, b3, b4;
  logic [IdxW-1:0] len_c, idx_n;
  logic [16:0]     sus;
  logic            run_n;
  logic [BndW-1:0] iw;
  logic signed [17:0] w_s;
  logic [17:0]     w_abs;
  logic [32:0]     sine_p;
  logic [15:0]     r2;
  logic [16:0]     nq, nt;
  logic [46:0]     gain_p;
  logic [13:0]     q_mag;
  logic            out_free;
  div_req_t        dreq;
  div_rsp_t        drsp;

  oav_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign sus = (cfg_i.sustain_lvl > EnvOne) ? EnvOne : cfg_i.sustain_lvl;
  assign b1  = BndW'(cfg_i.attack_len);
  assign b2  = b1 + BndW'(cfg_i.decay_len);
  assign b3  = b2 + BndW'(HoldLen);
  assign b4  = b3 + BndW'(cfg_i.release_len);
  assign sum_len = b4;
  assign len_c = (sum_len > MaxLen) ? IdxW'(MaxLen) : sum_len[IdxW-1:0];
  assign idx_n = q_start_i ? '0 : idx_q;
  assign run_n = (q_start_i || run_q) && (idx_n < len_c);
  assign iw    = BndW'(idx_q);

  always_comb begin
    sine_p = 33'(phase_q[30:15]) * 33'(EnvOne - 17'(phase_q[30:15]));
    r2 = {seed_q[30:16], 1'b0};
    nq = 17'(r2);
    nt = 17'(r2);
    if (nt >= 17'(NoiseDiv)) begin
      nq = nq + 17'd1;
      nt = nt - 17'(NoiseDiv);
    end
    if (nt >= 17'(NoiseDiv)) nq = nq + 17'd1;
    case (cfg_i.wave_sel)
      WaveSine: w_s = phase_q[31] ? -$signed({2'b00, sine_p[30:15]}) :
                                    $signed({2'b00, sine_p[30:15]});
      WaveSquare: w_s = phase_q[31] ? -$signed({2'b00, SquareAmp}) :
                                      $signed({2'b00, SquareAmp});
      WaveSaw: w_s = $signed({2'b00, phase_q[31:16]}) - 18'sd32768;
      WaveTri: begin
        if (phase_q[31:30] == 2'b00) begin
          w_s = $signed({3'b000, phase_q[29:15]});
        end else if (phase_q[31:30] == 2'b11) begin
          w_s = $signed({3'b000, phase_q[29:15]}) - 18'sd32768;
        end else begin
          w_s = 18'sd32768 - $signed({2'b00, 16'(phase_q[30:15] - 16'h8000)});
        end
      end
      WaveNoise: w_s = $signed({1'b0, nq}) - 18'sd32768;
      default: w_s = 18'sd0;
    endcase
    w_abs = w_s[17] ? 18'(-w_s) : 18'(w_s);
  end

  assign gain_p = 47'(prod_q) * 47'(OutGain);
  assign q_mag  = gain_p[44:31];
  assign out_free = !ov_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    dreq.start = 1'b0;
    dreq.num   = num_q;
    dreq.den   = den_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        state_d = run_n ? ST_SEG : ST_DONE;
      end
      ST_SEG: state_d = ST_WAVE;
      ST_WAVE: begin
        if (seg_q == SEG_HOLD) begin
          state_d = ST_ENV;
        end else begin
          dreq.start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: if (drsp.done) state_d = ST_ENV;
      ST_ENV: state_d = ST_GAIN;
      ST_GAIN: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 32'd0;
      idx_q   <= '0;
      seed_q  <= SeedInit;
      run_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (q_valid_i) begin
          if (q_start_i) begin
            phase_q <= 32'd0;
            idx_q   <= '0;
          end
          run_q <= run_n;
        end
        ST_SEG: if (cfg_i.wave_sel == WaveNoise) seed_q <= seed_q * LcgMul + LcgAdd;
        ST_GAIN: begin
          phase_q <= phase_q + cfg_i.phase_step;
          idx_q   <= idx_q + 1'b1;
          run_q   <= (idx_q + 1'b1) < len_q;
        end
        ST_DONE: if (out_free) ov_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        len_q      <= len_c;
        res_q      <= '0;
        res_last_q <= 1'b0;
        res_act_q  <= 1'b0;
      end
      ST_SEG: begin
        if (iw < b1) begin
          seg_q <= SEG_ATTACK;
          num_q <= {1'b0, idx_q, 16'd0};
          den_q <= cfg_i.attack_len;
        end else if (iw < b2) begin
          seg_q <= SEG_DECAY;
          num_q <= NumW'((EnvOne - sus) * 35'(idx_q - cfg_i.attack_len));
          den_q <= cfg_i.decay_len;
        end else if (iw < b3) begin
          seg_q <= SEG_HOLD;
        end else begin
          seg_q <= SEG_RELEASE;
          num_q <= NumW'(sus * 35'(IdxW'(b4 - iw)));
          den_q <= cfg_i.release_len;
        end
      end
      ST_WAVE: begin
        wneg_q <= w_s[17];
        wmag_q <= w_abs[15:0];
        env_q  <= sus;
      end
      ST_DIV: if (drsp.done) begin
        env_q <= (seg_q == SEG_DECAY) ? EnvOne - drsp.quot[EnvW-1:0] : drsp.quot[EnvW-1:0];
      end
      ST_ENV: prod_q <= 33'(wmag_q) * 33'(env_q);
      ST_GAIN: begin
        res_q      <= wneg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        res_last_q <= (idx_q == len_q - 1'b1);
        res_act_q  <= 1'b1;
      end
      ST_DONE: if (out_free) begin
        osamp_q <= res_q;
        olast_q <= res_last_q;
        oact_q  <= res_act_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ov_q;
  assign sample_out_o  = osamp_q;
  assign last_sample_o = olast_q;
  assign note_active_o = oact_q;

endmodule
`default_nettype wire

@@ rtl/oscillator_adsr_voice_unit.sv @@
// Top level of the oscillator voice with ADSR envelope.
//
//  Channel | Direction | Handshake               | Word
//  input   | in        | in_valid_i / in_stall_o  | note_start_i
//  output  | out       | out_valid_o / out_stall_i| sample_out_o, last_sample_o, note_active_o
//  config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A sounding tick passes through SEG, WAVE, DIV (the 35-step envelope divider), ENV,
// GAIN and DONE; a hold-phase tick skips DIV and an idle tick jumps to DONE.
// A two-word queue lets ticks be taken while the engine works on one.
// Reset clears phase, index and run state and sets the noise seed to 12345.
// A stalled output word holds; the engine waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module oscillator_adsr_voice_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic         note_start_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic signed [14:0] sample_out_o,
  output logic              last_sample_o,
  output logic              note_active_o,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  import oav_pkg::*;

  cfg_t cfg_q;
  logic q_valid, q_start, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_sel    <= RstWave;
      cfg_q.phase_step  <= RstStep;
      cfg_q.attack_len  <= RstAttack;
      cfg_q.decay_len   <= RstDecay;
      cfg_q.sustain_lvl <= RstSustain;
      cfg_q.release_len <= RstRelease;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWave:    cfg_q.wave_sel    <= cfg_data_i[2:0];
        RegStep:    cfg_q.phase_step  <= cfg_data_i;
        RegAttack:  cfg_q.attack_len  <= cfg_data_i[17:0];
        RegDecay:   cfg_q.decay_len   <= cfg_data_i[17:0];
        RegSustain: cfg_q.sustain_lvl <= cfg_data_i[16:0];
        RegRelease: cfg_q.release_len <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  oav_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .note_start_i(note_start_i),
    .q_valid_o(q_valid), .q_start_o(q_start), .q_pop_i(q_pop)
  );

  oav_engine u_engine (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_start_i(q_start), .q_pop_o(q_pop),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .sample_out_o(sample_out_o), .last_sample_o(last_sample_o),
    .note_active_o(note_active_o)
  );

endmodule
`default_nettype wire

@@ rtl/oav_checker.sv @@
// Port checker for the oscillator voice, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module oav_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [14:0] sample_out_o,
  input wire logic        last_sample_o,
  input wire logic        note_active_o
);

  // A final sample always belongs to a sounding note.
  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_sample_o |-> note_active_o) else $error("last without active");

  // Ticks outside a note give silence.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !note_active_o |-> sample_out_o == 15'd0) else $error("idle not zero");

  // The sample magnitude never exceeds the output gain.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(sample_out_o) <= 15'sd16000 &&
                     $signed(sample_out_o) >= -15'sd16000)) else $error("sample range");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled word changed");

endmodule

bind oscillator_adsr_voice_unit oav_checker u_oav_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .sample_out_o(sample_out_o), .last_sample_o(last_sample_o), .note_active_o(note_active_o)
);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the oscillator voice with ADSR envelope.
`timescale 1ns / 1ps
module tb;
  import oav_pkg::*;

  typedef struct {
    logic [14:0] sample;
    logic        last;
    logic        active;
  } voice_word_t;

  class voice_scoreboard;
    logic [2:0]  wave_sel;
    logic [31:0] step;
    logic [17:0] att_len;
    logic [17:0] dec_len;
    logic [16:0] sus_lvl;
    logic [17:0] rel_len;
    logic [31:0] phase;
    logic [31:0] index;
    logic [31:0] seed;
    bit          playing;
    voice_word_t awaited[$];
    int          mismatches;

    function new();
      wave_sel = RstWave;
      step = RstStep;
      att_len = RstAttack;
      dec_len = RstDecay;
      sus_lvl = RstSustain;
      rel_len = RstRelease;
      phase = 0;
      index = 0;
      seed = SeedInit;
      playing = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        RegWave:    wave_sel = v[2:0];
        RegStep:    step = v;
        RegAttack:  att_len = v[17:0];
        RegDecay:   dec_len = v[17:0];
        RegSustain: sus_lvl = v[16:0];
        RegRelease: rel_len = v[17:0];
        default: ;
      endcase
    endfunction

    function longint signed wave_now();
      logic [31:0] x;
      longint signed m;
      longint unsigned r;
      case (wave_sel)
        WaveSine: begin
          x = (phase >> 15) & 32'hFFFF;
          m = longint'((longint'(x) * (65536 - longint'(x))) >>> 15);
          return phase[31] ? -m : m;
        end
        WaveSquare: return phase[31] ? -19661 : 19661;
        WaveSaw:    return longint'(phase >> 16) - 32768;
        WaveTri: begin
          if (phase < 32'h4000_0000) return longint'(phase >> 15);
          if (phase < 32'hC000_0000) return 32768 - longint'((phase - 32'h4000_0000) >> 15);
          return longint'((phase - 32'hC000_0000) >> 15) - 32768;
        end
        WaveNoise: begin
          seed = seed * LcgMul + LcgAdd;
          r = (seed >> 16) & 32'h7FFF;
          return longint'((r * 65536) / 32767) - 32768;
        end
        default: return 0;
      endcase
    endfunction

    function longint unsigned envelope_at(longint unsigned i);
      longint unsigned a, d, r, s, h;
      a = att_len;
      d = dec_len;
      r = rel_len;
      h = HoldLen;
      s = (sus_lvl > 65536) ? 65536 : sus_lvl;
      if (i < a) return (i * 65536) / a;
      if (i < a + d) return 65536 - ((65536 - s) * (i - a)) / d;
      if (i < a + d + h) return s;
      if (i < a + d + h + r) return (s * (r - (i - a - d - h))) / r;
      return 0;
    endfunction

    function void note_input(bit start);
      longint unsigned len, mag, q;
      longint signed w;
      voice_word_t e;
      len = longint'(att_len) + dec_len + HoldLen + rel_len;
      if (len > MaxLen) len = MaxLen;
      if (len < 1) len = 1;
      e.sample = 0;
      e.last = 0;
      e.active = 0;
      if (start) begin
        phase = 0;
        index = 0;
        playing = 1;
      end
      if (playing && index >= len) playing = 0;
      if (playing) begin
        w = wave_now();
        mag = (w < 0) ? -w : w;
        q = (mag * envelope_at(index) * 16000) >> 31;
        e.sample = (w < 0) ? 15'(-q) : 15'(q);
        e.active = 1;
        e.last = (index == len - 1);
        phase = phase + step;
        index = index + 1;
        if (index >= len) playing = 0;
      end
      awaited.push_back(e);
    endfunction

    function void check_result(logic [14:0] s, logic l, logic a);
      voice_word_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: sample %0d", $signed(s));
        return;
      end
      e = awaited.pop_front();
      if (s !== e.sample || l !== e.last || a !== e.active) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b", $signed(e.sample),
                   e.last, e.active, $signed(s), l, a);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic note_start = 0;
  logic out_stall = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = 0;
  logic [31:0] cfg_data = 0;
  logic in_stall_o, out_valid_o, last_sample_o, note_active_o;
  logic signed [14:0] sample_out_o;

  voice_scoreboard sb = new();
  bit no_idle = 0;
  bit long_hold = 0;
  int sent = 0;

  oscillator_adsr_voice_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .note_start_i(note_start), .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .sample_out_o(sample_out_o), .last_sample_o(last_sample_o),
    .note_active_o(note_active_o), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task automatic wait_idle();
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_word(bit s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1;
    note_start <= s;
    do @(posedge clk_i); while (!(in_valid && !in_stall_o));
    sb.note_input(s);
    sent++;
  endtask

  task automatic end_burst();
    in_valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_voice(logic [2:0] w, logic [31:0] st, logic [17:0] a, logic [17:0] d,
                           logic [16:0] s, logic [17:0] r);
    wait_idle();
    write_reg(RegWave, w);
    write_reg(RegStep, st);
    write_reg(RegAttack, a);
    write_reg(RegDecay, d);
    write_reg(RegSustain, s);
    write_reg(RegRelease, r);
    cfg_we <= 0;
  endtask

  function automatic logic [17:0] rand_len();
    if ($urandom_range(0, 4) == 0) return 18'($urandom_range(0, 262143));
    return 18'($urandom_range(0, 200));
  endfunction

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        stall = 400;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_stall <= 1;
        repeat (stall) @(posedge clk_i);
      end
      out_stall <= 0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall));
      sb.check_result(sample_out_o, last_sample_o, note_active_o);
    end
  end

  initial begin
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_word(0);
    send_word(1);
    send_word(0);
    send_word(1);
    send_word(0);
    end_burst();
    for (int w = 0; w < 8; w++) begin
      set_voice(3'(w), (w % 2) ? 32'hFFFF_FFFF : 32'h0765_4321, (w == 2) ? 18'd0 : 18'd3,
                (w == 3) ? 18'd0 : 18'd2, (w == 4) ? 17'h1FFFF : 17'(w * 9000),
                (w == 5) ? 18'h3FFFF : 18'd4);
      send_word(1);
      send_word(0);
      end_burst();
    end

    set_voice(WaveTri, 32'h0123_4567, 18'd5, 18'd6, 17'd30000, 18'd7);
    no_idle = 1;
    send_word(1);
    for (int i = 0; i < 100; i++) send_word(0);
    send_word(1);
    for (int i = 0; i < 100; i++) send_word(0);
    end_burst();
    no_idle = 0;

    n = 0;
    while (n < 1700) begin
      set_voice((($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                 : 3'($urandom_range(0, 4))),
                ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 26))),
                rand_len(), rand_len(),
                ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                : 17'($urandom_range(0, 65536)), rand_len());
      if (n > 300 && n < 500) long_hold = 1;
      no_idle = ($urandom_range(0, 4) == 0);
      send_word($urandom_range(0, 7) != 0);
      for (int i = $urandom_range(20, 120); i > 0; i--) begin
        send_word($urandom_range(0, 63) == 0);
        n++;
      end
      end_burst();
      no_idle = 0;
    end

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
